// ===== hdl/nearest_palette_index_search_macros.svh =====
// assertion macros for the nearest palette index search checker
// no dependencies; included by the checker file only
`ifndef NEAREST_PALETTE_INDEX_SEARCH_MACROS_SVH
`define NEAREST_PALETTE_INDEX_SEARCH_MACROS_SVH

// same-cycle implication, masked during reset
`define NPIS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, masked during reset
`define NPIS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also covers reset itself
`define NPIS_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/npis_pkg.sv =====
// shared types and constants for the nearest palette index search
// no dependencies; imported by the datapath, controller and top level
`default_nettype none

package npis_pkg;

   localparam int PALETTE_DEPTH_DEF = 256;

   localparam logic [8:0] THRESH_RESET   = 9'd128;
   localparam logic [7:0] RESERVED_LOW   = 8'hF0;
   localparam logic [7:0] TRANSPARENT_IX = 8'd0;
   localparam logic [7:0] FALLBACK_IX    = 8'd1;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_MAP    = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic scan_step;
      logic load_rsp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_scan;
      logic scan_done;
      logic pipe_busy;
      logic rsp_free;
   } stat_type;

endpackage

`default_nettype wire

// ===== hdl/npis_datapath.sv =====
// datapath: palette memory, entry count, threshold, distance pipeline, result register
// depends on npis_pkg
`default_nettype none

module npis_datapath #(
   parameter int PALETTE_DEPTH = npis_pkg::PALETTE_DEPTH_DEF
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire npis_pkg::cmd_type  cmd,
   output npis_pkg::stat_type      stat,
   input  wire logic [1:0]     req_opcode,
   input  wire logic [7:0]     req_entry_number,
   input  wire logic [7:0]     req_red,
   input  wire logic [7:0]     req_green,
   input  wire logic [7:0]     req_blue,
   input  wire logic [7:0]     req_alpha,
   input  wire logic           csr_write_enable,
   input  wire logic [8:0]     csr_write_data,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output logic [7:0]          rsp_color_index,
   output logic                rsp_status
);
   import npis_pkg::*;

   localparam int CW = $clog2(PALETTE_DEPTH + 1);
   localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(PALETTE_DEPTH);

   logic [31:0]   mem [PALETTE_DEPTH];

   logic [8:0]    thr_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] addr_ff;
   logic [7:0]    pix_r_ff, pix_g_ff, pix_b_ff;
   logic [7:0]    res_idx_ff;
   logic          res_status_ff;
   logic          found_ff;

   // read stage
   logic          s1_valid_ff;
   logic [31:0]   rd_word_ff;
   // squared difference stage
   logic          s2_valid_ff;
   logic [7:0]    s2_num_ff;
   logic [15:0]   sq_r_ff, sq_g_ff, sq_b_ff;

   logic          rsp_valid_ff;
   logic [7:0]    rsp_idx_ff;
   logic          rsp_status_ff;

   op_type        op;
   logic          need_scan;
   logic [7:0]    s1_num;
   logic          s1_qualify;
   logic [7:0]    d_r, d_g, d_b;
   logic [17:0]   dist_sum;
   logic [17:0]   best_ff;
   logic          take_best;

   assign op        = op_type'(req_opcode);
   assign need_scan = (op == OP_MAP) && ({1'b0, req_alpha} >= thr_ff);

   assign s1_num     = rd_word_ff[31:24];
   assign s1_qualify = (s1_num != TRANSPARENT_IX) && (s1_num < RESERVED_LOW);

   assign d_r = (rd_word_ff[23:16] > pix_r_ff) ? rd_word_ff[23:16] - pix_r_ff
                                               : pix_r_ff - rd_word_ff[23:16];
   assign d_g = (rd_word_ff[15:8] > pix_g_ff) ? rd_word_ff[15:8] - pix_g_ff
                                              : pix_g_ff - rd_word_ff[15:8];
   assign d_b = (rd_word_ff[7:0] > pix_b_ff) ? rd_word_ff[7:0] - pix_b_ff
                                             : pix_b_ff - rd_word_ff[7:0];

   assign dist_sum  = 18'(sq_r_ff) + 18'(sq_g_ff) + 18'(sq_b_ff);
   assign take_best = s2_valid_ff && (!found_ff || (dist_sum < best_ff));

   assign stat.need_scan = need_scan;
   assign stat.scan_done = (addr_ff == count_ff);
   assign stat.pipe_busy = s1_valid_ff || s2_valid_ff;
   assign stat.rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_color_index = rsp_idx_ff;
   assign rsp_status      = rsp_status_ff;

   // palette memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.accept && (op == OP_APPEND) && (count_ff < DEPTH_C)) begin
         mem[count_ff[AW-1:0]] <= {req_entry_number, req_red, req_green, req_blue};
      end
      rd_word_ff <= mem[addr_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= THRESH_RESET;
         count_ff     <= '0;
         addr_ff      <= '0;
         found_ff     <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            thr_ff <= csr_write_data;
         end
         s1_valid_ff <= cmd.scan_step;
         s2_valid_ff <= s1_valid_ff && s1_qualify;
         if (cmd.accept) begin
            addr_ff  <= '0;
            found_ff <= 1'b0;
            case (op)
               OP_CLEAR: begin
                  count_ff <= '0;
               end
               OP_APPEND: begin
                  if (count_ff < DEPTH_C) begin
                     count_ff <= count_ff + 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end else begin
            if (cmd.scan_step) begin
               addr_ff <= addr_ff + 1'b1;
            end
            if (take_best) begin
               found_ff <= 1'b1;
            end
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s2_num_ff <= s1_num;
      sq_r_ff   <= 16'(d_r) * 16'(d_r);
      sq_g_ff   <= 16'(d_g) * 16'(d_g);
      sq_b_ff   <= 16'(d_b) * 16'(d_b);
      if (cmd.accept) begin
         pix_r_ff      <= req_red;
         pix_g_ff      <= req_green;
         pix_b_ff      <= req_blue;
         res_idx_ff    <= need_scan ? FALLBACK_IX : TRANSPARENT_IX;
         res_status_ff <= (op == OP_APPEND) && (count_ff >= DEPTH_C);
      end else if (take_best) begin
         res_idx_ff <= s2_num_ff;
         best_ff    <= dist_sum;
      end
      if (cmd.load_rsp) begin
         rsp_idx_ff    <= res_idx_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/npis_ctrl.sv =====
// controller state machine: accept, scan sequencing, drain, result hand-off
// depends on npis_pkg
`default_nettype none

module npis_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire npis_pkg::stat_type stat,
   output npis_pkg::cmd_type      cmd
);
   import npis_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = stat.need_scan ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            if (stat.scan_done) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!stat.pipe_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (stat.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall     = 1'b1;
      cmd.accept    = 1'b0;
      cmd.scan_step = 1'b0;
      cmd.load_rsp  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_SCAN: begin
            cmd.scan_step = !stat.scan_done;
         end
         ST_FINISH: begin
            cmd.load_rsp = stat.rsp_free;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/nearest_palette_index_search.sv =====
// top level of the nearest palette index search
// depends on npis_pkg, npis_ctrl and npis_datapath
//
//   port group   direction   handshake                 carries
//   req_*        in          req_valid / req_stall     opcode, entry number, rgba
//   rsp_*        out         rsp_valid / rsp_stall     color index, status
//   csr_*        in          csr_write_enable          alpha threshold, 9 bits
//
// clear, append and transparent map requests go from accept straight to the finish state, with no scan
// an opaque map scans the palette first: the palette memory read port
//   delivers one entry per cycle, then the read/square/compare pipeline drains
// one request is in flight at a time; req_stall is high from accept until the
//   result is loaded into the output register
// a held result (rsp_stall high) does not block the next request from being
//   accepted and worked on
// reset is synchronous and active high; palette contents are not cleared,
//   only the entry count, threshold, valid flags and control state
`default_nettype none

module nearest_palette_index_search #(
   parameter int PALETTE_DEPTH = npis_pkg::PALETTE_DEPTH_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // request channel
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_opcode,
   input  wire logic [7:0] req_entry_number,
   input  wire logic [7:0] req_red,
   input  wire logic [7:0] req_green,
   input  wire logic [7:0] req_blue,
   input  wire logic [7:0] req_alpha,
   // result channel
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_color_index,
   output logic            rsp_status,
   // threshold register
   input  wire logic       csr_write_enable,
   input  wire logic [8:0] csr_write_data
);
   import npis_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer: idle -> scan -> drain -> finish, or idle -> finish
   npis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // palette store, distance pipeline and output register
   npis_datapath #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_opcode       (req_opcode),
      .req_entry_number (req_entry_number),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .req_alpha        (req_alpha),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_color_index  (rsp_color_index),
      .rsp_status       (rsp_status)
   );

endmodule

`default_nettype wire

// ===== hdl/npis_checker.sv =====
// port-level checker for the nearest palette index search, with its bind
// depends on nearest_palette_index_search_macros.svh
`default_nettype none
`include "nearest_palette_index_search_macros.svh"

module npis_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_color_index,
   input wire logic       rsp_status
);

   // a dropped append never carries an index
   `NPIS_ASSERT_IMP(a_status_no_index, clock, reset, rsp_valid && rsp_status, rsp_color_index == 8'd0, "full-palette status with nonzero index")

   // one request in flight: stall rises right after an accept
   `NPIS_ASSERT_NXT(a_stall_after_accept, clock, reset, req_valid && !req_stall, req_stall, "request accepted while previous one still in flight")

   // a held result keeps its payload
   `NPIS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_color_index) && $stable(rsp_status), "stalled result changed")

   // reset empties the output register
   `NPIS_ASSERT_NXT_ALWAYS(a_reset_clears_rsp, clock, reset, !rsp_valid, "result valid after reset")

endmodule

bind nearest_palette_index_search npis_checker u_npis_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_color_index (rsp_color_index),
   .rsp_status      (rsp_status)
);

`default_nettype wire
